// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bqeq_pkg.sv -----
// ---------------------------------------------------------------------------
// bqeq_pkg
// shared constants, register indexes and datapath control for the biquad
// ---------------------------------------------------------------------------
package bqeq_pkg;

    localparam int COEF_BITS  = 32;
    localparam int STATE_BITS = 48;
    localparam int NUM_COEFS  = 5;
    localparam int REG_IDX_W  = 3;

    // coefficient register indexes
    localparam logic [REG_IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_A1 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_A2 = 3'd4;

    // per-step controls from the sequencer to the datapath
    typedef struct packed {
        logic ld_z;     // capture delay states, clear clip flag
        logic acc_z1;   // b0*x + z1
        logic do_y;     // round, shift, saturate output
        logic ld_u;     // hold b2*x
        logic sub_t;    // b1*x - a1*y
        logic do_n1;    // new z1, and b2*x - a2*y
        logic mul_y;    // multiplier takes y instead of x
    } dp_ctrl_t;

endpackage

// ----- rtl/bqeq_ram.sv -----
// ---------------------------------------------------------------------------
// bqeq_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module bqeq_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 2,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/bqeq_datapath.sv -----
// ---------------------------------------------------------------------------
// bqeq_datapath
// shared multiplier and accumulators for one transposed direct form ii step
// ---------------------------------------------------------------------------
module bqeq_datapath #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 22
) (
    input  logic                                     clk,
    input  bqeq_pkg::dp_ctrl_t                       ctrl,
    input  logic signed [bqeq_pkg::COEF_BITS-1:0]    coef_op,
    input  logic signed [SAMPLE_BITS-1:0]            x,
    input  logic signed [bqeq_pkg::STATE_BITS-1:0]   z1_in,
    input  logic signed [bqeq_pkg::STATE_BITS-1:0]   z2_in,
    output logic signed [SAMPLE_BITS-1:0]            y,
    output logic signed [bqeq_pkg::STATE_BITS-1:0]   n1,
    output logic signed [bqeq_pkg::STATE_BITS-1:0]   n2,
    output logic                                     clip
);

    import bqeq_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    localparam int AW     = PROD_W + 3;

    localparam logic signed [AW-1:0] ONE = AW'(1);
    // sums are bounded to 64-bit signed; only matters for wide samples
    localparam logic signed [AW-1:0] SAT_HI = (AW > 64) ? ((ONE <<< 63) - ONE)
                                                         : ~(ONE <<< (AW - 1));
    localparam logic signed [AW-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [AW-1:0] STA_HI = (ONE <<< (STATE_BITS - 1)) - ONE;
    localparam logic signed [AW-1:0] STA_LO = ~STA_HI;
    localparam logic signed [AW-1:0] Y_HI   = (ONE <<< (SAMPLE_BITS - 1)) - ONE;
    localparam logic signed [AW-1:0] Y_LO   = ~Y_HI;
    localparam logic signed [AW-1:0] RND    = ONE <<< (COEF_FRAC_BITS - 1);

    function automatic logic signed [AW-1:0] sat64(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI;
        else if (v < SAT_LO)
            r = SAT_LO;
        else
            r = v;
        return r;
    endfunction

    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [STATE_BITS-1:0]  z1_reg;
    logic signed [STATE_BITS-1:0]  z2_reg;
    logic signed [AW-1:0]          acc_reg;
    logic signed [AW-1:0]          t_reg;
    logic signed [AW-1:0]          u_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg;
    logic signed [STATE_BITS-1:0]  n1_reg;
    logic                          hit_reg;

    logic signed [SAMPLE_BITS-1:0] mul_b;
    logic signed [AW-1:0]          prod_ext;
    logic signed [AW-1:0]          acc_sum;
    logic signed [AW-1:0]          rnd_sum;
    logic signed [AW-1:0]          y_wide;
    logic signed [AW-1:0]          y_clamp;
    logic                          y_hit;
    logic signed [AW-1:0]          t_sub;
    logic signed [AW-1:0]          t_z2;
    logic signed [AW-1:0]          n1_clamp;
    logic                          n1_hit;
    logic signed [AW-1:0]          u_sub;
    logic signed [AW-1:0]          n2_clamp;
    logic                          n2_hit;

    assign mul_b    = ctrl.mul_y ? y_reg : x;
    assign prod_ext = AW'(prod_reg);

    always_comb
    begin
        acc_sum = sat64(prod_ext + AW'(z1_reg));
        rnd_sum = sat64(acc_reg + RND);
        y_wide  = rnd_sum >>> COEF_FRAC_BITS;
        y_hit   = (y_wide > Y_HI) || (y_wide < Y_LO);
        if (y_wide > Y_HI)
            y_clamp = Y_HI;
        else if (y_wide < Y_LO)
            y_clamp = Y_LO;
        else
            y_clamp = y_wide;

        t_sub  = sat64(t_reg - prod_ext);
        t_z2   = sat64(t_reg + AW'(z2_reg));
        n1_hit = (t_z2 > STA_HI) || (t_z2 < STA_LO);
        if (t_z2 > STA_HI)
            n1_clamp = STA_HI;
        else if (t_z2 < STA_LO)
            n1_clamp = STA_LO;
        else
            n1_clamp = t_z2;

        u_sub  = sat64(u_reg - prod_ext);
        n2_hit = (u_reg > STA_HI) || (u_reg < STA_LO);
        if (u_reg > STA_HI)
            n2_clamp = STA_HI;
        else if (u_reg < STA_LO)
            n2_clamp = STA_LO;
        else
            n2_clamp = u_reg;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(coef_op) * PROD_W'(mul_b);
        if (ctrl.ld_z)
        begin
            z1_reg  <= z1_in;
            z2_reg  <= z2_in;
            hit_reg <= 1'b0;
        end
        if (ctrl.acc_z1)
        begin
            acc_reg <= acc_sum;
        end
        if (ctrl.do_y)
        begin
            y_reg   <= y_clamp[SAMPLE_BITS-1:0];
            hit_reg <= hit_reg | y_hit;
            t_reg   <= prod_ext;
        end
        if (ctrl.ld_u)
        begin
            u_reg <= prod_ext;
        end
        if (ctrl.sub_t)
        begin
            t_reg <= t_sub;
        end
        if (ctrl.do_n1)
        begin
            n1_reg  <= n1_clamp[STATE_BITS-1:0];
            hit_reg <= hit_reg | n1_hit;
            u_reg   <= u_sub;
        end
    end

    assign y    = y_reg;
    assign n1   = n1_reg;
    assign n2   = n2_clamp[STATE_BITS-1:0];
    assign clip = hit_reg | n2_hit;

endmodule

// ----- rtl/biquad_peaking_eq_filter_core.sv -----
// ---------------------------------------------------------------------------
// biquad_peaking_eq_filter_core
// second-order iir section, transposed direct form ii, per-channel state
// ---------------------------------------------------------------------------
//  port group   dir   contents
//  s_*          in    request: sample, channel (tuser), end of block (tlast)
//  m_*          out   request: filtered sample, channel + clip (tuser), tlast
//  cfg_*        in    coefficient write: b0 b1 b2 a1 a2 at index 0..4
//
//  a sample is taken only in idle, so a new sample waits until the previous one
//  has reached the output register. the path to it is one state memory read,
//  five products through a single shared multiplier, then the state write-back,
//  done with the output load. a stalled output holds the last step until the
//  output register frees. reset loads pass-through coefficients and zeroes
//  every channel's state through per-channel valid bits; any coefficient write too
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module biquad_peaking_eq_filter_core #(
    parameter int CHANNELS       = 2,
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 22,
    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [TDATA_W-1:0]                 s_tdata,   // sample_in
    input  logic                               s_tuser,   // channel_in
    input  logic                               s_tlast,   // last_in
    // output stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [TDATA_W-1:0]                 m_tdata,   // sample_out
    output logic [1:0]                         m_tuser,   // channel_out, clipped
    output logic                               m_tlast,   // last_out
    // coefficient writes
    input  logic                               cfg_we,
    input  logic [bqeq_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [bqeq_pkg::COEF_BITS-1:0]     cfg_wdata
);

    import bqeq_pkg::*;

    localparam int CH_AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int WORD_W = 2 * STATE_BITS;

    // sequencer steps
    localparam logic [2:0] ST_IDLE = 3'd0;  // wait for a sample
    localparam logic [2:0] ST_RD   = 3'd1;  // state word arrives, b0*x
    localparam logic [2:0] ST_B0   = 3'd2;  // acc = b0*x + z1, b1*x
    localparam logic [2:0] ST_Y    = 3'd3;  // y, b2*x
    localparam logic [2:0] ST_A1   = 3'd4;  // a1*y
    localparam logic [2:0] ST_T1   = 3'd5;  // b1*x - a1*y, a2*y
    localparam logic [2:0] ST_N1   = 3'd6;  // new z1, b2*x - a2*y
    localparam logic [2:0] ST_N2   = 3'd7;  // new z2, write back, result out

    logic [2:0]                    state_reg;
    logic [2:0]                    state_next;

    logic signed [COEF_BITS-1:0]   coef_reg [NUM_COEFS];
    logic [CHANNELS-1:0]           valid_reg;

    // latched request
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic                          ch_reg;
    logic                          last_reg;
    logic [CH_AW-1:0]              ch_idx_reg;

    // output register
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic                          out_ch_reg;
    logic                          out_last_reg;
    logic                          out_clip_reg;

    logic                          accept;
    logic                          cfg_hit;
    logic                          out_load;
    logic [CH_AW-1:0]              in_ch_idx;
    logic [WORD_W-1:0]             mem_rdata;
    logic [WORD_W-1:0]             z_word;
    logic signed [COEF_BITS-1:0]   coef_op;
    dp_ctrl_t                      dp_ctrl;

    logic signed [SAMPLE_BITS-1:0] dp_y;
    logic signed [STATE_BITS-1:0]  dp_n1;
    logic signed [STATE_BITS-1:0]  dp_n2;
    logic                          dp_clip;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_hit   = cfg_we && (cfg_index < REG_IDX_W'(NUM_COEFS));
    // last step finishes only when the output slot is free
    assign out_load  = (state_reg == ST_N2) && (!out_valid_reg || m_tready);
    // channel index is the one-bit tuser; a single channel always uses index zero
    assign in_ch_idx = (CHANNELS > 1) ? CH_AW'(s_tuser) : '0;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_RD;
            ST_RD:   state_next = ST_B0;
            ST_B0:   state_next = ST_Y;
            ST_Y:    state_next = ST_A1;
            ST_A1:   state_next = ST_T1;
            ST_T1:   state_next = ST_N1;
            ST_N1:   state_next = ST_N2;
            ST_N2:   if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // multiplier operand and datapath controls per step
    always_comb
    begin
        dp_ctrl = '0;
        coef_op = '0;
        unique case (state_reg)
            ST_RD:
            begin
                dp_ctrl.ld_z = 1'b1;
                coef_op      = coef_reg[REG_B0];
            end
            ST_B0:
            begin
                dp_ctrl.acc_z1 = 1'b1;
                coef_op        = coef_reg[REG_B1];
            end
            ST_Y:
            begin
                dp_ctrl.do_y = 1'b1;
                coef_op      = coef_reg[REG_B2];
            end
            ST_A1:
            begin
                dp_ctrl.ld_u  = 1'b1;
                dp_ctrl.mul_y = 1'b1;
                coef_op       = coef_reg[REG_A1];
            end
            ST_T1:
            begin
                dp_ctrl.sub_t = 1'b1;
                dp_ctrl.mul_y = 1'b1;
                coef_op       = coef_reg[REG_A2];
            end
            ST_N1:
            begin
                dp_ctrl.do_n1 = 1'b1;
            end
            ST_IDLE, ST_N2:
            begin
                dp_ctrl = '0;
            end
            default:
            begin
                dp_ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            out_valid_reg    <= 1'b0;
            valid_reg        <= '0;
            coef_reg[REG_B0] <= COEF_BITS'(1) << COEF_FRAC_BITS;
            coef_reg[REG_B1] <= '0;
            coef_reg[REG_B2] <= '0;
            coef_reg[REG_A1] <= '0;
            coef_reg[REG_A2] <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            // a coefficient write zeroes every channel's delay states
            if (cfg_hit)
            begin
                coef_reg[cfg_index] <= cfg_wdata;
                valid_reg           <= '0;
            end
            else if (out_load)
            begin
                valid_reg[ch_idx_reg] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg      <= s_tdata[SAMPLE_BITS-1:0];
            ch_reg     <= s_tuser;
            last_reg   <= s_tlast;
            ch_idx_reg <= in_ch_idx;
        end
        if (out_load)
        begin
            out_sample_reg <= dp_y;
            out_ch_reg     <= ch_reg;
            out_last_reg   <= last_reg;
            out_clip_reg   <= dp_clip;
        end
    end

    // delay states {z2, z1} per channel, read at acceptance
    bqeq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .clk   (clk),
        .we    (out_load),
        .waddr (ch_idx_reg),
        .wdata ({dp_n2, dp_n1}),
        .re    (accept),
        .raddr (in_ch_idx),
        .rdata (mem_rdata)
    );

    // a channel not written since the last clear reads as zero
    assign z_word = valid_reg[ch_idx_reg] ? mem_rdata : '0;

    bqeq_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .clk     (clk),
        .ctrl    (dp_ctrl),
        .coef_op (coef_op),
        .x       (x_reg),
        .z1_in   ($signed(z_word[STATE_BITS-1:0])),
        .z2_in   ($signed(z_word[WORD_W-1:STATE_BITS])),
        .y       (dp_y),
        .n1      (dp_n1),
        .n2      (dp_n2),
        .clip    (dp_clip)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'($unsigned(out_sample_reg));
    assign m_tuser  = {out_clip_reg, out_ch_reg};
    assign m_tlast  = out_last_reg;

    `ASSERT_NEXT(a_cfg_clears_state, cfg_hit, valid_reg == '0, "delay states not cleared after coefficient write")
    `ASSERT_NEXT(a_accept_starts_read, accept, state_reg == ST_RD, "accepted sample did not start a state read")
    `ASSERT_IMPLIES(a_no_result_overwrite, out_load, !(out_valid_reg && !m_tready), "pending result overwritten")

endmodule

// ----- tb/sv/biquad_peaking_eq_filter_core_tb.sv -----
// ---------------------------------------------------------------------------
// biquad_peaking_eq_filter_core_tb
// self-checking bench for the per-channel biquad: a directed table covers
// pass-through, gain extremes, rounding, state saturation and ignored writes,
// then random coefficient phases with random sample requests; each output is
// checked with typed row values or a bit-true fixed-point model of the filter
// ---------------------------------------------------------------------------
module biquad_peaking_eq_filter_core_tb;

    import bqeq_pkg::*;

    localparam int SMP_W      = 24;
    localparam int FRAC_W     = 22;
    localparam int CHAN_N     = 2;
    localparam int ITEM_GOAL  = 1150;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int IDLE_PAUSE = 12;
    localparam int MAX_REPORTS = 40;

    localparam longint LONG_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint LONG_MIN = 64'sh8000_0000_0000_0000;
    localparam longint ROUND_HALF = 64'sd1 <<< (FRAC_W - 1);

    // sample extremes
    localparam int SMP_MAX = 8388607;
    localparam int SMP_MIN = -8388608;

    // coefficient values in q9.22
    localparam logic [COEF_BITS-1:0] COEF_MAX  = 32'h7FFF_FFFF;
    localparam logic [COEF_BITS-1:0] COEF_MIN  = 32'h8000_0000;
    localparam logic [COEF_BITS-1:0] COEF_ONE  = 32'h0040_0000;
    localparam logic [COEF_BITS-1:0] COEF_HALF = 32'h0020_0000;
    localparam logic [COEF_BITS-1:0] COEF_ZERO = 32'h0000_0000;

    // indexes past the coefficient list, writes there are dropped
    localparam logic [REG_IDX_W-1:0] IDX_UNUSED_LO = 3'd5;
    localparam logic [REG_IDX_W-1:0] IDX_UNUSED_HI = 3'd7;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [REG_IDX_W-1:0]   idx;
        logic [COEF_BITS-1:0]   value;
        logic [SMP_W-1:0]       sample;
        bit                     chan;
        bit                     last;
        bit                     typed;
        logic [SMP_W-1:0]       want;
        bit                     want_clip;
    } dir_row_t;

    typedef struct packed {
        logic [SMP_W-1:0]   sample;
        logic               chan;
        logic               last;
        logic               clip;
    } filt_out_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                   s_tvalid;
    logic                   s_tready;
    logic [SMP_W-1:0]       s_tdata;    // sample_in
    logic                   s_tuser;    // channel_in
    logic                   s_tlast;    // last_in
    logic                   m_tvalid;
    logic                   m_tready;
    logic [SMP_W-1:0]       m_tdata;    // sample_out
    logic [1:0]             m_tuser;    // channel_out, clipped
    logic                   m_tlast;    // last_out
    logic                   cfg_we;
    logic [REG_IDX_W-1:0]   cfg_index;
    logic [COEF_BITS-1:0]   cfg_wdata;

    // hand-typed expectation riding along with the pending request
    logic                   held_typed;
    logic [SMP_W-1:0]       held_want;
    logic                   held_clip;

    // model state: coefficients and per-channel delay pair
    longint coef_reg [NUM_COEFS];
    longint z1_state [CHAN_N];
    longint z2_state [CHAN_N];

    filt_out_t  filtered_q[$];
    dir_row_t   dir_rows[$];
    int         mismatch_count;
    int         cycle_count;
    int         samples_sent;
    bit         feed_calm;
    bit         sink_calm;

    always #1 clk = ~clk;

    biquad_peaking_eq_filter_core #(
        .CHANNELS       (CHAN_N),
        .SAMPLE_BITS    (SMP_W),
        .COEF_FRAC_BITS (FRAC_W)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // fixed-point filter model
    // ------------------------------------------------------------------

    // 64-bit add that pins at the rails instead of wrapping
    function automatic longint sat_sum(input longint a, input longint b);
        longint s;
        s = a + b;
        if (a < 0 && b < 0 && s >= 0)
            return LONG_MIN;
        if (a >= 0 && b >= 0 && s < 0)
            return LONG_MAX;
        return s;
    endfunction

    function automatic longint sat_negate(input longint a);
        return (a == LONG_MIN) ? LONG_MAX : -a;
    endfunction

    function automatic longint clamp_to(input longint v, input int bits, inout bit hit);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            hit = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            hit = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic void clear_delays();
        for (int c = 0; c < CHAN_N; c++)
        begin
            z1_state[c] = 0;
            z2_state[c] = 0;
        end
    endfunction

    // one tdf-ii step: y from b0*x + z1, then both delays from y
    function automatic filt_out_t filter_sample(input logic [SMP_W-1:0] raw,
                                                input logic chan, input logic last);
        longint     x;
        longint     acc;
        longint     y;
        longint     t;
        longint     n1;
        longint     n2;
        bit         hit;
        filt_out_t  r;
        hit = 1'b0;
        x   = $signed(raw);
        acc = sat_sum(coef_reg[REG_B0] * x, z1_state[chan]);
        acc = sat_sum(acc, ROUND_HALF);
        y   = clamp_to(acc >>> FRAC_W, SMP_W, hit);
        t   = sat_sum(coef_reg[REG_B1] * x, sat_negate(coef_reg[REG_A1] * y));
        t   = sat_sum(t, z2_state[chan]);
        n1  = clamp_to(t, STATE_BITS, hit);
        t   = sat_sum(coef_reg[REG_B2] * x, sat_negate(coef_reg[REG_A2] * y));
        n2  = clamp_to(t, STATE_BITS, hit);
        z1_state[chan] = n1;
        z2_state[chan] = n2;
        r.sample = y[SMP_W-1:0];
        r.chan   = chan;
        r.last   = last;
        r.clip   = hit;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // directed table rows
    // ------------------------------------------------------------------

    function automatic dir_row_t sample_row(input int smp, input bit chan, input bit last,
                                            input bit typed, input int want,
                                            input bit want_clip);
        dir_row_t r;
        r.kind      = ROW_SAMPLE;
        r.idx       = REG_B0;
        r.value     = COEF_ZERO;
        r.sample    = smp[SMP_W-1:0];
        r.chan      = chan;
        r.last      = last;
        r.typed     = typed;
        r.want      = want[SMP_W-1:0];
        r.want_clip = want_clip;
        return r;
    endfunction

    function automatic dir_row_t write_row(input logic [REG_IDX_W-1:0] idx,
                                           input logic [COEF_BITS-1:0] value);
        dir_row_t r;
        r = sample_row(0, 1'b0, 1'b0, 1'b0, 0, 1'b0);
        r.kind  = ROW_WRITE;
        r.idx   = idx;
        r.value = value;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // one sample request, with a random lead-in gap unless the phase is calm
    task automatic send_sample(input logic [SMP_W-1:0] smp, input bit chan, input bit last,
                               input bit typed, input logic [SMP_W-1:0] want,
                               input bit want_clip);
        int gap;
        gap = feed_calm ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= smp;
        s_tuser    <= chan;
        s_tlast    <= last;
        held_typed <= typed;
        held_want  <= want;
        held_clip  <= want_clip;
        do
            @(posedge clk);
        while (!s_tready);
        samples_sent++;
    endtask

    // drain every outstanding request, then hold the block quiet for IDLE_PAUSE
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        // let the checker log the last accepted request first
        @(posedge clk);
        while (filtered_q.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAUSE) @(posedge clk);
    endtask

    task automatic write_coef(input logic [REG_IDX_W-1:0] idx,
                              input logic [COEF_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [COEF_BITS-1:0] pick_coef();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       return COEF_MAX;
                    1:       return COEF_MIN;
                    2:       return COEF_ONE;
                    default: return COEF_ZERO;
                endcase
            end
            // magnitude below one, keeps most feedback settings stable
            1, 2, 3, 4: return COEF_BITS'($signed($urandom_range(0, 8388606)) - 4194303);
            5, 6:       return COEF_BITS'($signed($urandom_range(0, 16777214)) - 8388607);
            default:    return $urandom();
        endcase
    endfunction

    function automatic logic [SMP_W-1:0] pick_sample();
        int v;
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       v = SMP_MAX;
                    1:       v = SMP_MIN;
                    2:       v = 0;
                    default: v = -1;
                endcase
            end
            1, 2, 3: v = $signed($urandom_range(0, 8191)) - 4096;
            default: v = $urandom();
        endcase
        return v[SMP_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // model update and output check, all on the sampled edge values
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        filt_out_t want;
        filt_out_t got;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            // coefficient write: any listed register clears every delay pair
            if (rst_n && cfg_we && cfg_index < NUM_COEFS)
            begin
                coef_reg[cfg_index] = $signed(cfg_wdata);
                clear_delays();
            end

            // input request accepted: predict its output request
            if (rst_n && s_tvalid && s_tready)
            begin
                want = filter_sample(s_tdata, s_tuser, s_tlast);
                if (held_typed)
                begin
                    want.sample = held_want;
                    want.clip   = held_clip;
                end
                filtered_q.push_back(want);
            end

            // output request accepted: compare with the oldest prediction
            if (rst_n && m_tvalid && m_tready)
            begin
                got.sample = m_tdata;
                got.chan   = m_tuser[0];
                got.clip   = m_tuser[1];
                got.last   = m_tlast;
                if (filtered_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t unexpected output: expected none got sample %0d",
                                 $time, $signed(got.sample));
                end
                else
                begin
                    want = filtered_q.pop_front();
                    if (got.sample !== want.sample)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t sample mismatch: expected %0d got %0d", $time,
                                     $signed(want.sample), $signed(got.sample));
                    end
                    if (got.chan !== want.chan)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t channel mismatch: expected %0d got %0d", $time,
                                     want.chan, got.chan);
                    end
                    if (got.last !== want.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t last mismatch: expected %0d got %0d", $time,
                                     want.last, got.last);
                    end
                    if (got.clip !== want.clip)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("%0t clip mismatch: expected %0d got %0d", $time,
                                     want.clip, got.clip);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output side: random back-pressure per request, none in calm phases
    // ------------------------------------------------------------------
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge clk);
        forever
        begin
            stall = sink_calm ? 0 : $urandom_range(0, 8);
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int         phase_len;
        int         writes;
        dir_row_t   row;
        logic [REG_IDX_W-1:0] idx;

        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        s_tlast        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        held_typed     = 1'b0;
        held_want      = '0;
        held_clip      = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        samples_sent   = 0;
        feed_calm      = 1'b0;
        sink_calm      = 1'b0;

        // reset state: unity pass-through, delays zero
        coef_reg[REG_B0] = longint'(COEF_ONE);
        coef_reg[REG_B1] = 0;
        coef_reg[REG_B2] = 0;
        coef_reg[REG_A1] = 0;
        coef_reg[REG_A2] = 0;
        clear_delays();

        // pass-through after reset, sample extremes on both channels
        dir_rows.push_back(sample_row(0,       1'b0, 1'b0, 1'b1, 0,       1'b0));
        dir_rows.push_back(sample_row(SMP_MAX, 1'b1, 1'b1, 1'b1, SMP_MAX, 1'b0));
        dir_rows.push_back(sample_row(SMP_MIN, 1'b0, 1'b0, 1'b1, SMP_MIN, 1'b0));
        dir_rows.push_back(sample_row(-1,      1'b1, 1'b0, 1'b1, -1,      1'b0));
        dir_rows.push_back(sample_row(1,       1'b0, 1'b1, 1'b1, 1,       1'b0));
        // largest positive gain: output clips both ways
        dir_rows.push_back(write_row(REG_B0, COEF_MAX));
        dir_rows.push_back(sample_row(SMP_MAX, 1'b0, 1'b0, 1'b1, SMP_MAX, 1'b1));
        dir_rows.push_back(sample_row(SMP_MIN, 1'b1, 1'b1, 1'b1, SMP_MIN, 1'b1));
        dir_rows.push_back(sample_row(1,       1'b0, 1'b0, 1'b1, 512,     1'b0));
        // largest negative gain
        dir_rows.push_back(write_row(REG_B0, COEF_MIN));
        dir_rows.push_back(sample_row(SMP_MAX, 1'b1, 1'b0, 1'b1, SMP_MIN, 1'b1));
        dir_rows.push_back(sample_row(SMP_MIN, 1'b0, 1'b0, 1'b1, SMP_MAX, 1'b1));
        // half gain: exact halves round up
        dir_rows.push_back(write_row(REG_B0, COEF_HALF));
        dir_rows.push_back(sample_row(1,  1'b0, 1'b0, 1'b1, 1,  1'b0));
        dir_rows.push_back(sample_row(-1, 1'b1, 1'b0, 1'b1, 0,  1'b0));
        dir_rows.push_back(sample_row(3,  1'b0, 1'b0, 1'b1, 2,  1'b0));
        dir_rows.push_back(sample_row(-3, 1'b1, 1'b1, 1'b1, -1, 1'b0));
        // huge feedback: delay state saturates, output itself in range
        dir_rows.push_back(write_row(REG_B0, COEF_ONE));
        dir_rows.push_back(write_row(REG_A1, COEF_MIN));
        dir_rows.push_back(sample_row(SMP_MAX, 1'b0, 1'b0, 1'b1, SMP_MAX, 1'b1));
        dir_rows.push_back(sample_row(0,       1'b0, 1'b0, 1'b0, 0,       1'b0));
        // other channel's delays untouched by channel 0 traffic
        dir_rows.push_back(sample_row(0,       1'b1, 1'b0, 1'b1, 0,       1'b0));
        // writes past the list must leave delays alone
        dir_rows.push_back(write_row(IDX_UNUSED_LO, COEF_MAX));
        dir_rows.push_back(sample_row(0, 1'b0, 1'b1, 1'b0, 0, 1'b0));
        dir_rows.push_back(write_row(IDX_UNUSED_HI, COEF_ZERO));
        // every tap but b0 at an extreme
        dir_rows.push_back(write_row(REG_A2, COEF_MAX));
        dir_rows.push_back(write_row(REG_B1, COEF_MIN));
        dir_rows.push_back(write_row(REG_B2, COEF_MAX));
        dir_rows.push_back(sample_row(SMP_MIN, 1'b1, 1'b0, 1'b0, 0, 1'b0));
        dir_rows.push_back(sample_row(SMP_MAX, 1'b1, 1'b1, 1'b0, 0, 1'b0));
        dir_rows.push_back(sample_row(SMP_MIN, 1'b0, 1'b0, 1'b0, 0, 1'b0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: writes only once the pipe has drained
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.kind == ROW_WRITE)
            begin
                wait_idle();
                write_coef(row.idx, row.value);
            end
            else
            begin
                send_sample(row.sample, row.chan, row.last, row.typed, row.want,
                            row.want_clip);
            end
        end

        // random phases: new coefficient set, then a burst of sample requests
        while (samples_sent < ITEM_GOAL)
        begin
            wait_idle();
            feed_calm = ($urandom_range(0, 3) == 0);
            sink_calm = ($urandom_range(0, 3) == 0);
            writes = $urandom_range(1, 6);
            repeat (writes)
            begin
                if ($urandom_range(0, 9) == 0)
                    idx = REG_IDX_W'($urandom_range(NUM_COEFS, 7));
                else
                    idx = REG_IDX_W'($urandom_range(0, NUM_COEFS - 1));
                write_coef(idx, pick_coef());
            end
            phase_len = $urandom_range(20, 90);
            repeat (phase_len)
                send_sample(pick_sample(), 1'($urandom_range(0, 1)),
                            ($urandom_range(0, 7) == 0), 1'b0, '0, 1'b0);
        end

        // drain, then a short quiet tail for any stray output
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (filtered_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
